// File: sv/joystick_to_gamepad_event_translator_macros.svh
// Assertion macros shared by the translator RTL.
`ifndef JOYSTICK_TO_GAMEPAD_EVENT_TRANSLATOR_MACROS_SVH
`define JOYSTICK_TO_GAMEPAD_EVENT_TRANSLATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define JGEV_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define JGEV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/jgev_pkg.sv
// Types, constants and helper functions for the joystick event translator.
package jgev_pkg;

   localparam int NUM_BUTTONS = 16;
   localparam int BTN_LIMIT   = 21;
   localparam int MAP_W       = 48;
   localparam int MAP_SLOTS   = MAP_W / 3;
   localparam int SLOT_IDX_W  = $clog2(MAP_SLOTS);
   localparam int MAP_POS_W   = $clog2(MAP_W);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 64;

   localparam logic [MAP_W-1:0] MAP_RESET    = 48'hFAC688FAC688;
   localparam logic [6:0]       DIGITAL_RESET = 7'd0;
   localparam logic [7:0]       ANALOG_RESET  = 8'hFF;
   localparam logic [14:0]      THRESH_RESET  = 15'd10000;

   localparam logic [6:0] EV_BUTTON = 7'd1;
   localparam logic [6:0] EV_AXIS   = 7'd2;

   localparam logic [23:0] BTN_UP    = 24'h000010;
   localparam logic [23:0] BTN_RIGHT = 24'h000020;
   localparam logic [23:0] BTN_DOWN  = 24'h000040;
   localparam logic [23:0] BTN_LEFT  = 24'h000080;

   localparam logic signed [16:0] AXIS_MAX = 17'sd32767;

   typedef enum logic [1:0] {
      KIND_DOWN = 2'd0,
      KIND_UP   = 2'd1,
      KIND_X    = 2'd2,
      KIND_Y    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      REG_BUTTON_MAP   = 2'd0,
      REG_DIGITAL_AXIS = 2'd1,
      REG_ANALOG_AXIS  = 2'd2,
      REG_THRESHOLD    = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic [MAP_W-1:0] button_map;
      logic [6:0]       digital_axis;
      logic [7:0]       analog_axis;
      logic [14:0]      threshold;
   } cfg_type;

   // One queued event: mask bits are release-first, release-second,
   // press/button, analog, emitted in that order.
   typedef struct packed {
      logic [3:0]  mask;
      logic        vert;
      kind_type    r2_kind;
      logic [23:0] r2_bits;
      logic [7:0]  quot;
   } entry_type;

   function automatic logic [23:0] slot_bits(input logic [2:0] slot);
      logic [23:0] bits;
      unique case (slot)
         3'd0: bits = 24'h004000;
         3'd1: bits = 24'h002000;
         3'd2: bits = 24'h001000;
         3'd3: bits = 24'h008000;
         3'd4: bits = 24'h000100;
         3'd5: bits = 24'h000200;
         3'd6: bits = 24'h000008;
         default: bits = 24'h000001;
      endcase
      return bits;
   endfunction

   // slots past the end of the map read as slot 0
   function automatic logic [2:0] map_slot(input logic [MAP_W-1:0] map,
                                           input logic [7:0] num);
      logic [2:0] slot;
      if (num < 8'(MAP_SLOTS)) begin
         slot = map[MAP_POS_W'(3 * num[SLOT_IDX_W-1:0]) +: 3];
      end else begin
         slot = 3'd0;
      end
      return slot;
   endfunction

endpackage

// File: sv/jgev_front.sv
// Front end: accepts events, updates held buttons, classifies results.
module jgev_front
   import jgev_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_event_type,
   input  logic [7:0]       req_event_number,
   input  logic signed [15:0] req_event_value,
   output logic             q_wr,
   output entry_type        q_wr_data,
   input  logic             q_full
);

   logic [23:0] held_ff, held_in;
   logic        s1_valid_ff, s1_valid_in;
   logic [3:0]  s1_mask_ff;
   logic        s1_vert_ff;
   kind_type    s1_kind_ff;
   logic [23:0] s1_bits_ff;
   logic [23:0] s1_prod_ff;

   logic        accept;
   logic [6:0]  ev_type;
   logic        is_btn, is_axis, btn_ok, dig_hit, ana_hit, vert;
   logic [23:0] btn_bit, first, second, pos, neg, cur;
   logic        rel_first, rel_second, press;
   logic signed [16:0] val17, thr17, shifted;
   logic [23:0] prod;
   logic [3:0]  mask;
   kind_type    r2_kind;
   logic [23:0] r2_bits;
   logic [7:0]  q0;
   logic [8:0]  q1;
   logic [24:0] q1_scaled;

   always_comb begin
      req_stall = s1_valid_ff && q_full;
      accept    = req_valid && !req_stall;

      ev_type = req_event_type[6:0];
      is_btn  = (ev_type == EV_BUTTON);
      is_axis = (ev_type == EV_AXIS);
      btn_ok  = (req_event_number < 8'(NUM_BUTTONS)) && (req_event_number < 8'(BTN_LIMIT));
      btn_bit = slot_bits(map_slot(cfg.button_map, req_event_number));

      vert    = req_event_number[0];
      dig_hit = (req_event_number[7:1] == cfg.digital_axis);
      ana_hit = !cfg.analog_axis[7] && (req_event_number[7:1] == cfg.analog_axis[6:0]);

      pos    = vert ? BTN_DOWN : BTN_RIGHT;
      neg    = vert ? BTN_UP : BTN_LEFT;
      first  = vert ? BTN_UP : BTN_RIGHT;
      second = vert ? BTN_DOWN : BTN_LEFT;

      val17 = {req_event_value[15], req_event_value};
      thr17 = {2'b00, cfg.threshold};
      priority if (val17 > thr17) begin
         cur = pos;
      end else if (val17 < -thr17) begin
         cur = neg;
      end else begin
         cur = '0;
      end

      rel_first  = ((held_ff & first) != '0) && (cur != first);
      rel_second = ((held_ff & second) != '0) && (cur != second);
      press      = (cur != '0) && ((held_ff & cur) == '0);

      // (value + 32767) * 255; the only negative sum is -1, which scales to 0
      shifted = val17 + AXIS_MAX;
      if (shifted[16]) begin
         prod = '0;
      end else begin
         prod = {shifted[15:0], 8'h00} - {8'h00, shifted[15:0]};
      end

      mask    = '0;
      r2_kind = KIND_DOWN;
      r2_bits = cur;
      held_in = held_ff;
      if (is_btn && btn_ok) begin
         mask[2] = 1'b1;
         r2_bits = btn_bit;
         if (req_event_value != '0) begin
            r2_kind = KIND_DOWN;
            held_in = held_ff | btn_bit;
         end else begin
            r2_kind = KIND_UP;
            held_in = held_ff & ~btn_bit;
         end
      end else if (is_axis) begin
         if (dig_hit) begin
            mask[0] = rel_first;
            mask[1] = rel_second;
            mask[2] = press;
            held_in = (held_ff & ~(rel_first ? first : 24'h0) & ~(rel_second ? second : 24'h0))
                      | (press ? cur : 24'h0);
         end
         mask[3] = ana_hit;
      end
      if (!accept) begin
         held_in = held_ff;
      end

      q_wr = s1_valid_ff && !q_full;
      s1_valid_in = (accept && (mask != '0)) ? 1'b1 : (q_wr ? 1'b0 : s1_valid_ff);

      // product / 65534: the >>16 estimate is low by at most one
      q0        = s1_prod_ff[23:16];
      q1        = {1'b0, q0} + 9'd1;
      q1_scaled = {q1, 16'h0000} - {15'h0000, q1, 1'b0};

      q_wr_data.mask    = s1_mask_ff;
      q_wr_data.vert    = s1_vert_ff;
      q_wr_data.r2_kind = s1_kind_ff;
      q_wr_data.r2_bits = s1_bits_ff;
      q_wr_data.quot    = ({1'b0, s1_prod_ff} >= q1_scaled) ? q1[7:0] : q0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         held_ff     <= held_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mask_ff <= mask;
         s1_vert_ff <= vert;
         s1_kind_ff <= r2_kind;
         s1_bits_ff <= r2_bits;
         s1_prod_ff <= prod;
      end
   end

endmodule

// File: sv/jgev_queue.sv
// Small FIFO of classified events between front and back ends.
module jgev_queue
   import jgev_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      wr,
   input  entry_type wr_data,
   output logic      full,
   input  logic      rd,
   output entry_type rd_data,
   output logic      not_empty
);

   entry_type          slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   always_comb begin
      full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
      not_empty = (count_ff != '0);
      rd_data   = slots_ff[rd_ptr_ff];
      wr_ptr_in = wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(wr) - QCNT_W'(rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         slots_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: sv/jgev_back.sv
// Back end: walks each queued event and emits one result per cycle unless the output is stalled.
module jgev_back
   import jgev_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_not_empty,
   input  entry_type   q_rd_data,
   output logic        q_rd,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_out_kind,
   output logic [23:0] rsp_out_payload,
   output logic        rsp_out_last
);

   logic [3:0]  work_mask_ff, work_mask_in;
   entry_type   work_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff;
   logic [23:0] payload_ff;
   logic        last_ff;

   logic        out_free, emit;
   logic [3:0]  sel, rest;
   kind_type    kind;
   logic [23:0] payload;

   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      emit     = out_free && (work_mask_ff != '0);

      priority if (work_mask_ff[0]) begin
         sel     = 4'b0001;
         kind    = KIND_UP;
         payload = work_ff.vert ? BTN_UP : BTN_RIGHT;
      end else if (work_mask_ff[1]) begin
         sel     = 4'b0010;
         kind    = KIND_UP;
         payload = work_ff.vert ? BTN_DOWN : BTN_LEFT;
      end else if (work_mask_ff[2]) begin
         sel     = 4'b0100;
         kind    = work_ff.r2_kind;
         payload = work_ff.r2_bits;
      end else begin
         sel     = 4'b1000;
         kind    = work_ff.vert ? KIND_Y : KIND_X;
         payload = {16'h0000, work_ff.quot};
      end

      rest = work_mask_ff & ~sel;
      q_rd = q_not_empty && ((work_mask_ff == '0) || (emit && (rest == '0)));

      if (q_rd) begin
         work_mask_in = q_rd_data.mask;
      end else if (emit) begin
         work_mask_in = rest;
      end else begin
         work_mask_in = work_mask_ff;
      end

      rsp_valid_in = emit || !out_free;

      rsp_valid       = rsp_valid_ff;
      rsp_out_kind    = kind_ff;
      rsp_out_payload = payload_ff;
      rsp_out_last    = last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_mask_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         work_mask_ff <= work_mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_rd) begin
         work_ff <= q_rd_data;
      end
      if (emit) begin
         kind_ff    <= kind;
         payload_ff <= payload;
         last_ff    <= (rest == '0);
      end
   end

endmodule

// File: sv/joystick_to_gamepad_event_translator.sv
// Top level of the joystick to gamepad event translator.
//
//   port group   direction  handshake          contents
//   req_*        in         valid / stall      one raw joystick event
//   rsp_*        out        valid / stall      one gamepad result
//   csr_*        in/out     APB-style, 64 bit  four configuration registers
//
// The front stage takes one event transfer per cycle and registers its
// classification; events with no result stop there, the rest enter a 4-entry queue.
// The back end emits one result per cycle, so an event yields 1 to 3 results;
// its first result passes the front register, the queue, the work and output registers.
// Reset is synchronous; it clears held buttons, queue and output valid.
// A stalled output holds; input stalls once the queue and front stage are full.
`include "joystick_to_gamepad_event_translator_macros.svh"

module joystick_to_gamepad_event_translator
   import jgev_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // event input
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_event_type,
   input  logic [7:0]            req_event_number,
   input  logic signed [15:0]    req_event_value,
   // result output
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_out_kind,
   output logic [23:0]           rsp_out_payload,
   output logic                  rsp_out_last,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type     cfg_ff, cfg_in;
   logic        cfg_wr;
   reg_idx_type reg_idx;

   logic        q_wr, q_rd, q_full, q_not_empty;
   entry_type   q_wr_data, q_rd_data;

   // ---------------------------------------------------------------
   // Configuration registers: 8-byte stride, low address bits ignored
   // ---------------------------------------------------------------
   always_comb begin
      csr_pready = 1'b1;
      reg_idx    = reg_idx_type'(csr_paddr[4:3]);
      cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
      cfg_in     = cfg_ff;
      if (cfg_wr) begin
         unique case (reg_idx)
            REG_BUTTON_MAP:   cfg_in.button_map   = csr_pwdata[MAP_W-1:0];
            REG_DIGITAL_AXIS: cfg_in.digital_axis = csr_pwdata[6:0];
            REG_ANALOG_AXIS:  cfg_in.analog_axis  = csr_pwdata[7:0];
            REG_THRESHOLD:    cfg_in.threshold    = csr_pwdata[14:0];
         endcase
      end
      unique case (reg_idx)
         REG_BUTTON_MAP:   csr_prdata = CSR_DATA_W'(cfg_ff.button_map);
         REG_DIGITAL_AXIS: csr_prdata = CSR_DATA_W'(cfg_ff.digital_axis);
         REG_ANALOG_AXIS:  csr_prdata = CSR_DATA_W'(cfg_ff.analog_axis);
         REG_THRESHOLD:    csr_prdata = CSR_DATA_W'(cfg_ff.threshold);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.button_map   <= MAP_RESET;
         cfg_ff.digital_axis <= DIGITAL_RESET;
         cfg_ff.analog_axis  <= ANALOG_RESET;
         cfg_ff.threshold    <= THRESH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------------------------------------------------------
   // Front end: one event per cycle unless stalled, owns the held-button state
   // ---------------------------------------------------------------
   jgev_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_event_type   (req_event_type),
      .req_event_number (req_event_number),
      .req_event_value  (req_event_value),
      .q_wr             (q_wr),
      .q_wr_data        (q_wr_data),
      .q_full           (q_full)
   );

   // decouples event intake from result drain
   jgev_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr        (q_wr),
      .wr_data   (q_wr_data),
      .full      (q_full),
      .rd        (q_rd),
      .rd_data   (q_rd_data),
      .not_empty (q_not_empty)
   );

   // ---------------------------------------------------------------
   // Back end: one result transfer per cycle unless stalled, into the output register
   // ---------------------------------------------------------------
   jgev_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_not_empty     (q_not_empty),
      .q_rd_data       (q_rd_data),
      .q_rd            (q_rd),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_kind    (rsp_out_kind),
      .rsp_out_payload (rsp_out_payload),
      .rsp_out_last    (rsp_out_last)
   );

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   // analog results are scaled to 0..255
   `JGEV_ASSERT_NOW(a_analog_range, rsp_valid && rsp_out_kind[1], rsp_out_payload[23:8] == 16'h0, "analog payload above 255")
   // button results carry exactly one button bit
   `JGEV_ASSERT_NOW(a_button_onehot, rsp_valid && !rsp_out_kind[1], $onehot(rsp_out_payload), "button payload not one-hot")
   // the rest of an event follows its non-final result without a gap
   `JGEV_ASSERT_NEXT(a_no_gap, rsp_valid && !rsp_stall && !rsp_out_last, rsp_valid, "gap inside one event's results")
   // the queue never takes an entry while full
   `JGEV_ASSERT_NOW(a_queue_wr, q_wr, !q_full, "queue write while full")

endmodule
